FILE: src/ctok_pkg.sv
// Shared types and constants of the C subset tokenizer.
// Used by ctok_lexer and c_subset_tokenizer; depends on nothing else.
package ctok_pkg;

  // Token kinds as they leave the block. Kinds 2 and 3 are never produced.
  typedef enum logic [4:0] {
    KIND_IDENT  = 5'd0,
    KIND_NUMBER = 5'd1,
    KIND_INT    = 5'd4,
    KIND_FLOAT  = 5'd5,
    KIND_VOID   = 5'd6,
    KIND_IF     = 5'd7,
    KIND_ELSE   = 5'd8,
    KIND_WHILE  = 5'd9,
    KIND_FOR    = 5'd10,
    KIND_RETURN = 5'd11,
    KIND_PLUS   = 5'd12,
    KIND_MINUS  = 5'd13,
    KIND_STAR   = 5'd14,
    KIND_SLASH  = 5'd15,
    KIND_ASSIGN = 5'd16,
    KIND_SEMI   = 5'd17,
    KIND_LPAREN = 5'd18,
    KIND_RPAREN = 5'd19,
    KIND_LBRACE = 5'd20,
    KIND_RBRACE = 5'd21,
    KIND_COMMA  = 5'd22,
    KIND_END    = 5'd23,
    KIND_BAD    = 5'd24
  } tok_kind_e;

  // Scan modes of the lexer.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_DROP = 2'd3
  } mode_e;

  // One token as it is queued and sent.
  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [7:0]  bad;
    logic        last;
  } res_t;

  // Up to two tokens produced by one request.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } lex_out_t;

  // Keywords packed with their first byte in the low bits.
  localparam int unsigned NUM_KW = 8;
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    {24'd0, "tni"},
    {8'd0,  "taolf"},
    {16'd0, "diov"},
    {32'd0, "fi"},
    {16'd0, "esle"},
    {8'd0,  "elihw"},
    {24'd0, "rof"},
    "nruter"
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6
  };
  localparam tok_kind_e KW_KIND [NUM_KW] = '{
    KIND_INT, KIND_FLOAT, KIND_VOID, KIND_IF,
    KIND_ELSE, KIND_WHILE, KIND_FOR, KIND_RETURN
  };

  // Number of bytes of a word kept for keyword matching.
  localparam int unsigned PREFIX_BYTES = 6;

  // Output queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

endpackage

FILE: src/ctok_lexer.sv
// Lexer core: scan state and the single-pass step that turns one request
// into up to two tokens. Depends on ctok_pkg.
module ctok_lexer #(
  parameter int POS_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              cmd_i,
  input  logic [7:0]        char_i,
  output ctok_pkg::lex_out_t out_o
);
  import ctok_pkg::*;

  typedef logic [POS_BITS-1:0] pos_t;

  mode_e       mode_q, mode_d;
  pos_t        start_q, start_d;
  pos_t        bpos_q, bpos_d;
  logic [47:0] prefix_q, prefix_d;
  pos_t        wlen_q, wlen_d;

  logic [7:0]  lower;
  logic        is_letter, is_digit, is_space, is_under;
  tok_kind_e   punct_kind, kw_kind;
  logic [15:0] start_c, bpos_c, wlen_c;
  logic        flush_v, b_v;
  res_t        flush_r, b_r;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + POS_BITS'(1);
  endfunction

  // Byte classes.
  assign lower     = char_i | 8'h20;
  assign is_letter = (lower >= 8'h61) && (lower <= 8'h7A);
  assign is_digit  = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign is_space  = (char_i == 8'h20) || ((char_i >= 8'h09) && (char_i <= 8'h0D));
  assign is_under  = (char_i == 8'h5F);

  // Single-byte operators and punctuators; identifier kind means none.
  always_comb begin
    unique case (char_i)
      8'h2B:   punct_kind = KIND_PLUS;
      8'h2D:   punct_kind = KIND_MINUS;
      8'h2A:   punct_kind = KIND_STAR;
      8'h2F:   punct_kind = KIND_SLASH;
      8'h3D:   punct_kind = KIND_ASSIGN;
      8'h3B:   punct_kind = KIND_SEMI;
      8'h28:   punct_kind = KIND_LPAREN;
      8'h29:   punct_kind = KIND_RPAREN;
      8'h7B:   punct_kind = KIND_LBRACE;
      8'h7D:   punct_kind = KIND_RBRACE;
      8'h2C:   punct_kind = KIND_COMMA;
      default: punct_kind = KIND_IDENT;
    endcase
  end

  // Keyword match of the pending word; words longer than six never match.
  always_comb begin
    kw_kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if ((wlen_q == POS_BITS'(KW_LEN[k])) && (prefix_q == KW_TEXT[k])) begin
        kw_kind = KW_KIND[k];
      end
    end
  end

  // Clamp positions and lengths to the 16-bit output fields.
  if (POS_BITS > 16) begin : g_clamp
    assign start_c = (|start_q[POS_BITS-1:16]) ? 16'hFFFF : start_q[15:0];
    assign bpos_c  = (|bpos_q[POS_BITS-1:16])  ? 16'hFFFF : bpos_q[15:0];
    assign wlen_c  = (|wlen_q[POS_BITS-1:16])  ? 16'hFFFF : wlen_q[15:0];
  end else begin : g_noclamp
    assign start_c = 16'(start_q);
    assign bpos_c  = 16'(bpos_q);
    assign wlen_c  = 16'(wlen_q);
  end

  // Token for the pending word or number.
  always_comb begin
    flush_r.kind  = (mode_q == MODE_WORD) ? kw_kind : KIND_NUMBER;
    flush_r.start = start_c;
    flush_r.len   = wlen_c;
    flush_r.bad   = 8'd0;
    flush_r.last  = 1'b0;
  end

  // Next scan state and the second token of this request.
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    bpos_d   = bpos_q;
    prefix_d = prefix_q;
    wlen_d   = wlen_q;
    flush_v  = 1'b0;
    b_v      = 1'b0;
    b_r.kind  = KIND_END;
    b_r.start = bpos_c;
    b_r.len   = 16'd0;
    b_r.bad   = 8'd0;
    b_r.last  = 1'b1;
    if (cmd_i) begin
      // End mark: flush and close the text, unless it was already rejected.
      if (mode_q != MODE_DROP) begin
        flush_v = (mode_q == MODE_WORD) || (mode_q == MODE_NUM);
        b_v     = 1'b1;
      end
      mode_d   = MODE_IDLE;
      start_d  = '0;
      bpos_d   = '0;
      prefix_d = '0;
      wlen_d   = '0;
    end else begin
      bpos_d = sat_inc(bpos_q);
      if (mode_q == MODE_DROP) begin
        // Bytes after an invalid byte are discarded.
      end else if ((mode_q == MODE_WORD) && (is_letter || is_digit || is_under)) begin
        for (int b = 0; b < PREFIX_BYTES; b++) begin
          if (wlen_q == POS_BITS'(b)) begin
            prefix_d[8*b +: 8] = char_i;
          end
        end
        wlen_d = sat_inc(wlen_q);
      end else if ((mode_q == MODE_NUM) && is_digit) begin
        wlen_d = sat_inc(wlen_q);
      end else begin
        // The byte ends any pending token and is classified on its own.
        flush_v  = (mode_q == MODE_WORD) || (mode_q == MODE_NUM);
        mode_d   = MODE_IDLE;
        prefix_d = '0;
        wlen_d   = '0;
        if (is_space) begin
          // Whitespace is skipped.
        end else if (is_letter || is_under) begin
          mode_d   = MODE_WORD;
          start_d  = bpos_q;
          prefix_d = {40'd0, char_i};
          wlen_d   = POS_BITS'(1);
        end else if (is_digit) begin
          mode_d  = MODE_NUM;
          start_d = bpos_q;
          wlen_d  = POS_BITS'(1);
        end else if (punct_kind != KIND_IDENT) begin
          b_v      = 1'b1;
          b_r.kind = punct_kind;
          b_r.len  = 16'd1;
        end else begin
          b_v      = 1'b1;
          b_r.kind = KIND_BAD;
          b_r.len  = 16'd1;
          b_r.bad  = char_i;
          mode_d   = MODE_DROP;
        end
      end
    end
  end

  // Pack the tokens so the first valid one is always in slot zero.
  always_comb begin
    out_o.v0      = step_i && (flush_v || b_v);
    out_o.v1      = step_i && flush_v && b_v;
    out_o.r0      = flush_v ? flush_r : b_r;
    out_o.r0.last = !(flush_v && b_v);
    out_o.r1      = b_r;
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      start_q  <= '0;
      bpos_q   <= '0;
      prefix_q <= '0;
      wlen_q   <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      bpos_q   <= bpos_d;
      prefix_q <= prefix_d;
      wlen_q   <= wlen_d;
    end
  end

endmodule

FILE: src/c_subset_tokenizer.sv
// Top level of the C subset tokenizer: input register, lexer core and a
// four-entry token queue. Depends on ctok_pkg and ctok_lexer.
//
// Usage: source text enters on the s_axis channel, one byte per request;
// s_axis_tuser high marks the end of the text instead of a byte. Tokens
// leave on the m_axis channel in source order, with the kind in tuser and
// start, length and offending byte in tdata. tlast marks the final token
// caused by one input request; requests that cause no token (word or
// number bytes, whitespace, bytes after an invalid byte) produce nothing.
// A token is offered after the request that caused it has passed the
// input register and has been written into the token queue.
// Throughput: one request per cycle while each request yields at most one
// token and the queue has room. A request that yields two tokens (a pending
// word or number followed by a punctuator or the end token) needs two m_axis
// transfers, which the queue absorbs; the single m_axis port sets that limit.
// Reset clears the scan state, the input register and the queue; the
// first byte after reset is position zero, as after every end mark.
// When the receiver stalls, tokens wait in the queue and s_axis_tready
// falls once fewer than two queue entries are free.
module c_subset_tokenizer #(
  parameter int POS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length,
                                      // [39:32] bad_byte
  output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);
  import ctok_pkg::*;

  logic                  in_valid_q;
  logic                  in_cmd_q;
  logic [7:0]            in_char_q;
  logic                  consume, room, pop;
  lex_out_t              lex;
  res_t                  mem [FIFO_DEPTH];
  res_t                  head;
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q, wptr_nx;
  logic [FIFO_CNT_W-1:0] count_q;
  logic [1:0]            push_n;

  // Queue room for two tokens after this cycle's read.
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign room    = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2)) ||
                   ((count_q == FIFO_CNT_W'(FIFO_DEPTH - 1)) && pop);
  assign consume = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || consume;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
  end

  // Lexer core.
  ctok_lexer #(
    .POS_BITS(POS_BITS)
  ) u_lexer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(consume),
    .cmd_i (in_cmd_q),
    .char_i(in_char_q),
    .out_o (lex)
  );

  // Token queue storage; slot one is only used together with slot zero.
  assign wptr_nx = wptr_q + FIFO_PTR_W'(1);
  assign push_n  = {1'b0, lex.v0} + {1'b0, lex.v1};

  always_ff @(posedge clk_i) begin
    if (lex.v0) begin
      mem[wptr_q] <= lex.r0;
    end
    if (lex.v1) begin
      mem[wptr_nx] <= lex.r1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + FIFO_PTR_W'(push_n);
      rptr_q  <= rptr_q + FIFO_PTR_W'(pop);
      count_q <= count_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end
  end

  // Output channel.
  assign head          = mem[rptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {head.bad, head.len, head.start};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  // The queue never holds more tokens than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("token queue overflow");

  // The end token always closes the run of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_END)) |-> m_axis_tlast)
    else $error("end token without tlast");

  // Only an invalid-byte token carries a nonzero offending byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_BAD)) |-> (m_axis_tdata[39:32] == 8'd0))
    else $error("offending byte set on a valid token");

  // A second token in one request is never written without room for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lex.v1 |-> (lex.v0 && room))
    else $error("second token pushed without a first or without room");

endmodule

FILE: tb/c_subset_tokenizer_tb.sv
// Self-checking testbench of the C subset tokenizer (c_subset_tokenizer).
// Drives source bytes and end marks with random gaps and receiver stalls and checks every
// token against a behavioral lexer kept in this file or a typed-in row. Depends on ctok_pkg.
`timescale 1ns / 100ps

module c_subset_tokenizer_tb;
  import ctok_pkg::*;

  // One row of the directed table. A negative n_typed means the lexer model decides.
  typedef struct {
    bit          cmd;
    logic [7:0]  ch;
    int          n_typed;
    res_t        t0;
    res_t        t1;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [39:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Keyword spellings and the kinds they map to.
  string     kw_spell [8] = '{"int", "float", "void", "if", "else", "while", "for", "return"};
  tok_kind_e kw_code [8] = '{KIND_INT, KIND_FLOAT, KIND_VOID, KIND_IF,
                             KIND_ELSE, KIND_WHILE, KIND_FOR, KIND_RETURN};
  string     punct_chars = "+-*/=;(){},";

  // Lexer model state.
  mode_e       lex_mode;
  logic [15:0] lex_start;
  logic [15:0] lex_pos;
  logic [47:0] lex_prefix;
  logic [15:0] lex_len;

  // Tokens produced by the latest request, and tokens still owed by the block.
  res_t     step_tok [2];
  int       step_n;
  res_t     tokens_due [$];
  dir_row_t dir_rows [$];

  int tx_max = 8;
  int rx_max = 8;
  int rx_wait = 0;
  int n_errors = 0;
  int n_counted = 0;

  c_subset_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic res_t mk_tok(tok_kind_e k, logic [15:0] s, logic [15:0] l,
                                  logic [7:0] b, logic last);
    res_t r;
    r.kind  = k;
    r.start = s;
    r.len   = l;
    r.bad   = b;
    r.last  = last;
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Returns KIND_IDENT when the byte is not an operator or punctuator.
  function automatic tok_kind_e punct_of(logic [7:0] c);
    case (c)
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "*": return KIND_STAR;
      "/": return KIND_SLASH;
      "=": return KIND_ASSIGN;
      ";": return KIND_SEMI;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      ",": return KIND_COMMA;
      default: return KIND_IDENT;
    endcase
  endfunction

  // A word is a keyword only if both its length and its stored prefix match.
  function automatic tok_kind_e keyword_of(logic [47:0] pfx, logic [15:0] len);
    logic [47:0] spelled;
    string       s;
    for (int k = 0; k < 8; k++) begin
      s = kw_spell[k];
      spelled = '0;
      for (int n = 0; n < s.len(); n++) begin
        spelled[8*n +: 8] = s[n];
      end
      if ((len == s.len()) && (pfx == spelled)) begin
        return kw_code[k];
      end
    end
    return KIND_IDENT;
  endfunction

  task automatic add_tok(tok_kind_e k, logic [15:0] s, logic [15:0] l, logic [7:0] b);
    step_tok[step_n] = mk_tok(k, s, l, b, 1'b0);
    step_n++;
  endtask

  // Emit the pending word or number, if any, and go back to idle.
  task automatic flush_pending();
    if (lex_mode == MODE_WORD) begin
      add_tok(keyword_of(lex_prefix, lex_len), lex_start, lex_len, 8'h00);
    end else if (lex_mode == MODE_NUM) begin
      add_tok(KIND_NUMBER, lex_start, lex_len, 8'h00);
    end
    lex_mode   = MODE_IDLE;
    lex_prefix = '0;
    lex_len    = '0;
  endtask

  task automatic lex_clear();
    lex_mode   = MODE_IDLE;
    lex_start  = '0;
    lex_pos    = '0;
    lex_prefix = '0;
    lex_len    = '0;
  endtask

  // Advance the lexer model by one request and collect the tokens it causes.
  task automatic tokenize_step(bit cmd, logic [7:0] ch);
    logic [15:0] pos;
    tok_kind_e   pk;
    pos    = lex_pos;
    step_n = 0;
    if (cmd) begin
      // An end mark after an invalid byte gives nothing; otherwise flush and end.
      if (lex_mode != MODE_DROP) begin
        flush_pending();
        add_tok(KIND_END, pos, 16'd0, 8'h00);
      end
      lex_clear();
    end else begin
      lex_pos = sat_inc(lex_pos);
      pk = punct_of(ch);
      if (lex_mode == MODE_DROP) begin
        // Bytes after an invalid byte are dropped.
      end else if ((lex_mode == MODE_WORD) && (is_alpha(ch) || is_num(ch) || (ch == "_"))) begin
        if (lex_len < 16'd6) begin
          lex_prefix[8*lex_len +: 8] = ch;
        end
        lex_len = sat_inc(lex_len);
      end else if ((lex_mode == MODE_NUM) && is_num(ch)) begin
        lex_len = sat_inc(lex_len);
      end else begin
        flush_pending();
        if (is_ws(ch)) begin
          // Whitespace only ends the pending token.
        end else if (is_alpha(ch) || (ch == "_")) begin
          lex_mode   = MODE_WORD;
          lex_start  = pos;
          lex_prefix = {40'd0, ch};
          lex_len    = 16'd1;
        end else if (is_num(ch)) begin
          lex_mode   = MODE_NUM;
          lex_start  = pos;
          lex_prefix = '0;
          lex_len    = 16'd1;
        end else if (pk != KIND_IDENT) begin
          add_tok(pk, pos, 16'd1, 8'h00);
        end else begin
          add_tok(KIND_BAD, pos, 16'd1, ch);
          lex_mode = MODE_DROP;
        end
      end
    end
    if (step_n > 0) begin
      step_tok[step_n-1].last = 1'b1;
    end
  endtask

  task automatic queue_step_tokens();
    for (int i = 0; i < step_n; i++) begin
      tokens_due.push_back(step_tok[i]);
    end
  endtask

  // Offer one request after a random gap and hold it until it is accepted.
  task automatic drive_req(bit cmd, logic [7:0] ch);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_req(bit cmd, logic [7:0] ch);
    if (cmd || (lex_mode != MODE_DROP)) begin
      n_counted++;
    end
    drive_req(cmd, ch);
    tokenize_step(cmd, ch);
    queue_step_tokens();
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_req(1'b0, s[i]);
    end
  endtask

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = first ? $urandom_range(0, 52) : $urandom_range(0, 63);
    if (r < 26) begin
      return 8'(r) + "A";
    end else if (r < 52) begin
      return 8'(r - 26) + "a";
    end else if (r < 62 && r > 52) begin
      return 8'(r - 53) + "0";
    end
    return "_";
  endfunction

  function automatic logic [7:0] ws_char();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'd32 : 8'(r);
  endfunction

  // One random source text: mostly well-formed tokens, sometimes glued together,
  // with occasional noise bytes, always closed by an end mark.
  task automatic send_random_text();
    int n_tok;
    int pick;
    int len;
    n_tok = $urandom_range(1, 12);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_string(kw_spell[$urandom_range(0, 7)]);
        if ($urandom_range(0, 3) == 0) begin
          send_req(1'b0, word_char(1'b0));
        end
      end else if (pick < 45) begin
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
          send_req(1'b0, word_char(i == 0));
        end
      end else if (pick < 60) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          send_req(1'b0, 8'($urandom_range(0, 9)) + "0");
        end
      end else if (pick < 85) begin
        send_req(1'b0, punct_chars[$urandom_range(0, 10)]);
      end else if (pick < 97) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          send_req(1'b0, ws_char());
        end
      end else begin
        send_req(1'b0, 8'($urandom_range(0, 255)));
      end
      // Separators are optional so that adjacent tokens also merge.
      if ($urandom_range(0, 1) == 0) begin
        send_req(1'b0, ws_char());
      end
    end
    send_req(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_row(bit cmd, logic [7:0] ch, int n_typed, res_t t0, res_t t1);
    dir_row_t row;
    row.cmd     = cmd;
    row.ch      = ch;
    row.n_typed = n_typed;
    row.t0      = t0;
    row.t1      = t1;
    dir_rows.push_back(row);
  endtask

  // Receiver: check each accepted token, then stall at random before accepting another.
  always @(posedge clk_i) begin
    res_t want;
    int   w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected token: kind %0d start %0d", m_axis_tuser, m_axis_tdata[15:0]);
        n_errors++;
      end else begin
        want = tokens_due.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("token_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[15:0] !== want.start) begin
          $error("token_start: expected %0d, actual %0d", want.start, m_axis_tdata[15:0]);
          n_errors++;
        end
        if (m_axis_tdata[31:16] !== want.len) begin
          $error("token_length: expected %0d, actual %0d", want.len, m_axis_tdata[31:16]);
          n_errors++;
        end
        if (m_axis_tdata[39:32] !== want.bad) begin
          $error("bad_byte: expected %0d, actual %0d", want.bad, m_axis_tdata[39:32]);
          n_errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, m_axis_tlast);
          n_errors++;
        end
      end
      w = $urandom_range(0, rx_max);
      rx_wait       <= w;
      m_axis_tready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end
  end

  initial begin
    res_t none;
    none = '0;
    lex_clear();

    // Directed table: error cases and extremes typed in, the rest from the model.
    add_row(1'b0, 8'h00, 1, mk_tok(KIND_BAD, 16'd0, 16'd1, 8'h00, 1'b1), none);
    add_row(1'b0, "q",   0, none, none);
    add_row(1'b1, 8'hFF, 0, none, none);
    add_row(1'b1, 8'h00, 1, mk_tok(KIND_END, 16'd0, 16'd0, 8'h00, 1'b1), none);
    add_row(1'b0, "Z",   -1, none, none);
    add_row(1'b0, "_",   -1, none, none);
    add_row(1'b0, "9",   -1, none, none);
    add_row(1'b0, "+",   -1, none, none);
    add_row(1'b0, "0",   -1, none, none);
    add_row(1'b0, 8'd9,  -1, none, none);
    add_row(1'b0, "i",   -1, none, none);
    add_row(1'b0, "f",   -1, none, none);
    add_row(1'b0, 8'd13, -1, none, none);
    add_row(1'b0, "(",   -1, none, none);
    add_row(1'b0, ")",   -1, none, none);
    add_row(1'b0, "*",   -1, none, none);
    add_row(1'b0, "/",   -1, none, none);
    add_row(1'b0, "-",   -1, none, none);
    add_row(1'b0, "=",   -1, none, none);
    add_row(1'b0, ";",   -1, none, none);
    add_row(1'b0, "{",   -1, none, none);
    add_row(1'b0, "}",   -1, none, none);
    add_row(1'b0, ",",   -1, none, none);
    add_row(1'b0, "a",   -1, none, none);
    add_row(1'b0, 8'hFF, -1, none, none);
    add_row(1'b1, "x",   0, none, none);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      drive_req(dir_rows[i].cmd, dir_rows[i].ch);
      tokenize_step(dir_rows[i].cmd, dir_rows[i].ch);
      if (dir_rows[i].n_typed < 0) begin
        queue_step_tokens();
      end else begin
        if (dir_rows[i].n_typed > 0) tokens_due.push_back(dir_rows[i].t0);
        if (dir_rows[i].n_typed > 1) tokens_due.push_back(dir_rows[i].t1);
      end
    end

    // Hold off the sender until the block has drained.
    s_axis_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);

    // One long word sent back to back while the receiver never stalls.
    tx_max = 0;
    rx_max = 0;
    for (int i = 0; i < 40; i++) begin
      send_req(1'b0, "x");
    end
    send_req(1'b0, "+");
    send_req(1'b1, 8'h00);

    // Random texts, switching between busy and idle stretches on both sides.
    n_counted = 0;
    while (n_counted < 900) begin
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      send_random_text();
    end

    s_axis_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
